FILE: hdl/tkvp_pkg.sv
// Shared types, constants and key name table for the telemetry key/value parser.
`timescale 1ns / 1ps

package tkvp_pkg;

   // Default number of key characters kept
   localparam int KEY_CHARS_DEF = 7;
   // Longest name in the key table
   localparam int NAME_CHARS    = 4;
   localparam int NAME_COUNT    = 16;

   localparam int CSR_INDEX_W   = 8;
   localparam int CSR_DATA_W    = 8;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LOSS_LIMIT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ARC_CODE   = 8'd1;

   // Configuration reset values
   localparam logic [7:0] LOSS_LIMIT_RST = 8'd20;
   localparam logic [7:0] ARC_CODE_RST   = 8'd5;

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;

   // Field ids with side effects
   localparam logic [3:0] FID_V   = 4'd0;
   localparam logic [3:0] FID_ES  = 4'd2;
   localparam logic [3:0] FID_RDY = 4'd7;
   localparam logic [3:0] FID_ERR = 4'd12;

   // Value limits
   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [35:0] MAG_MAX = 36'h0_8000_0000;

   // Key names, first character in the low byte
   localparam logic [31:0] NAME_TAB [NAME_COUNT] = '{
      32'h0000_0056, // V
      32'h0050_7356, // VsP
      32'h0000_5345, // ES
      32'h0000_6F50, // Po
      32'h0072_7453, // Str
      32'h0000_7055, // Up
      32'h006E_7744, // Dwn
      32'h0079_6452, // Rdy
      32'h0062_7250, // Prb
      32'h006C_6F43, // Col
      32'h0072_6F43, // Cor
      32'h006D_694C, // Lim
      32'h0072_7245, // Err
      32'h6761_6944, // Diag
      32'h0053_4849, // IHS
      32'h0000_6453  // Sd
   };
   localparam logic [2:0] NAME_LEN [NAME_COUNT] = '{
      3'd1, 3'd3, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd2
   };

   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,
      KIND_EOL  = 2'd1,
      KIND_TICK = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_SEEK = 3'd0,
      PH_KEY  = 3'd1,
      PH_VWS  = 3'd2,
      PH_VDIG = 3'd3,
      PH_TAIL = 3'd4
   } phase_type;

   typedef enum logic {
      RK_FIELD  = 1'b0,
      RK_STATUS = 1'b1
   } rkind_type;

   typedef struct packed {
      logic [7:0] loss_limit;
      logic [7:0] arc_code;
   } cfg_type;

   typedef struct packed {
      rkind_type          result_kind;
      logic [3:0]         field_id;
      logic signed [31:0] field_value;
      logic               arc_on;
      logic               link_lost;
      logic               line_valid;
   } rsp_type;

endpackage

FILE: hdl/tkvp_key_match.sv
// Key lookup against the 16 telemetry field names.
`timescale 1ns / 1ps

module tkvp_key_match #(
   parameter int KEY_CHARS = tkvp_pkg::KEY_CHARS_DEF,
   parameter int LENW      = $clog2(KEY_CHARS + 1)
) (
   input  logic [7:0]      key_chars [KEY_CHARS],
   input  logic [LENW-1:0] key_len,
   output logic            hit,
   output logic [3:0]      field_id
);
   import tkvp_pkg::*;

   logic name_eq [NAME_COUNT];

   // Per-name compare: length equal and the first name_len bytes equal
   always_comb begin
      for (int i = 0; i < NAME_COUNT; i++) begin
         name_eq[i] = (LENW'(NAME_LEN[i]) == key_len);
         for (int j = 0; j < NAME_CHARS; j++) begin
            if (3'(j) < NAME_LEN[i] && key_chars[j] != NAME_TAB[i][8*j +: 8]) begin
               name_eq[i] = 1'b0;
            end
         end
      end
   end

   // Lowest matching id wins
   always_comb begin
      hit      = 1'b0;
      field_id = '0;
      for (int i = NAME_COUNT - 1; i >= 0; i--) begin
         if (name_eq[i]) begin
            hit      = 1'b1;
            field_id = 4'(i);
         end
      end
   end

endmodule

FILE: hdl/tkvp_parser.sv
// Line parser state, value accumulator, link loss counter and result formation.
`timescale 1ns / 1ps

module tkvp_parser #(
   parameter int KEY_CHARS = tkvp_pkg::KEY_CHARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [1:0]        kind,
   input  logic [7:0]        char_code,
   input  tkvp_pkg::cfg_type cfg,
   output logic              res_valid,
   output tkvp_pkg::rsp_type res
);
   import tkvp_pkg::*;

   localparam int LENW = $clog2(KEY_CHARS + 1);
   localparam int IDXW = $clog2(KEY_CHARS);

   // State registers
   phase_type        phase_ff, phase_in;
   logic [7:0]       key_ff [KEY_CHARS];
   logic [LENW-1:0]  key_len_ff, key_len_in;
   logic [31:0]      accum_ff, accum_in;
   logic             neg_ff, neg_in;
   logic             dead_ff, dead_in;
   logic             crit_ff, crit_in;
   logic [31:0]      seq_ff, seq_in;
   logic [7:0]       tick_ff, tick_in;
   logic             lost_ff, lost_in;

   // Key write port
   logic             key_we;
   logic [IDXW-1:0]  key_widx;

   // Decode and commit
   kind_type         kind_t;
   logic             is_eol, is_chr, value_ph, is_sep, is_digit, is_letter, is_ws;
   logic             commit, hit, fire, line_ok;
   logic [3:0]       fid;
   logic [31:0]      commit_val;
   logic [35:0]      mul_acc;
   logic [7:0]       tick_inc;

   tkvp_key_match #(
      .KEY_CHARS (KEY_CHARS),
      .LENW      (LENW)
   ) u_key_match (
      .key_chars (key_ff),
      .key_len   (key_len_ff),
      .hit       (hit),
      .field_id  (fid)
   );

   // Character classes
   always_comb begin
      kind_t    = kind_type'(kind);
      is_eol    = (kind_t == KIND_EOL) || (kind_t == KIND_CHAR && char_code == CH_LF);
      is_chr    = (kind_t == KIND_CHAR) && (char_code != CH_LF) && (char_code != CH_CR)
                  && !dead_ff;
      value_ph  = phase_ff inside {PH_VWS, PH_VDIG, PH_TAIL};
      is_sep    = (char_code == CH_COMMA) || (char_code == CH_SEMI);
      is_digit  = char_code inside {[8'h30:8'h39]};
      is_letter = char_code inside {[8'h41:8'h5A], [8'h61:8'h7A]};
      is_ws     = char_code inside {CH_SPACE, CH_TAB, CH_VT, CH_FF};
   end

   // Decimal accumulate (x10 as shift-add) and signed commit value
   always_comb begin
      mul_acc    = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0}
                   + {32'd0, char_code[3:0]};
      commit_val = neg_ff ? (32'd0 - accum_ff) : (accum_ff[31] ? POS_MAX : accum_ff);
      commit     = value_ph && ((is_eol && !dead_ff)
                                || (is_chr && (char_code == CH_NUL || is_sep)));
      fire       = commit && hit;
      tick_inc   = (tick_ff != 8'hFF) ? tick_ff + 8'd1 : tick_ff;
   end

   // Next state and result
   always_comb begin
      phase_in   = phase_ff;
      key_len_in = key_len_ff;
      accum_in   = accum_ff;
      neg_in     = neg_ff;
      dead_in    = dead_ff;
      crit_in    = crit_ff;
      seq_in     = seq_ff;
      tick_in    = tick_ff;
      lost_in    = lost_ff;
      key_we     = 1'b0;
      key_widx   = key_len_ff[IDXW-1:0];
      res_valid  = 1'b0;
      line_ok    = 1'b0;
      res        = '0;

      // Effects of a committed known pair
      if (fire && fid == FID_ES) begin
         seq_in = commit_val;
      end
      if (fire && (fid == FID_V || fid == FID_RDY || fid == FID_ERR)) begin
         crit_in = 1'b1;
      end

      if (kind_t == KIND_TICK) begin
         tick_in   = tick_inc;
         lost_in   = lost_ff || (tick_inc > cfg.loss_limit);
         res_valid = 1'b1;
         res.result_kind = RK_STATUS;
      end else if (is_eol) begin
         line_ok    = crit_in;
         if (line_ok) begin
            tick_in = '0;
            lost_in = 1'b0;
         end
         phase_in   = PH_SEEK;
         key_len_in = '0;
         dead_in    = 1'b0;
         crit_in    = 1'b0;
         res_valid  = 1'b1;
         res.result_kind = fire ? RK_FIELD : RK_STATUS;
         res.line_valid  = line_ok;
      end else if (is_chr) begin
         res_valid       = fire;
         res.result_kind = RK_FIELD;
         if (char_code == CH_NUL) begin
            phase_in = PH_SEEK;
            dead_in  = 1'b1;
         end else begin
            case (phase_ff)
               PH_SEEK: begin
                  if (is_letter) begin
                     key_we     = 1'b1;
                     key_widx   = '0;
                     key_len_in = LENW'(1);
                     phase_in   = PH_KEY;
                  end
               end
               PH_KEY: begin
                  if (char_code == CH_COLON) begin
                     accum_in = '0;
                     neg_in   = 1'b0;
                     phase_in = PH_VWS;
                  end else if (key_len_ff < LENW'(KEY_CHARS)) begin
                     key_we     = 1'b1;
                     key_len_in = key_len_ff + LENW'(1);
                  end
               end
               PH_VWS: begin
                  if (is_sep) begin
                     phase_in = PH_SEEK;
                  end else if (is_ws) begin
                     phase_in = PH_VWS;
                  end else if (char_code == CH_PLUS) begin
                     phase_in = PH_VDIG;
                  end else if (char_code == CH_MINUS) begin
                     neg_in   = 1'b1;
                     phase_in = PH_VDIG;
                  end else if (is_digit) begin
                     accum_in = {28'd0, char_code[3:0]};
                     phase_in = PH_VDIG;
                  end else begin
                     phase_in = PH_TAIL;
                  end
               end
               PH_VDIG: begin
                  if (is_sep) begin
                     phase_in = PH_SEEK;
                  end else if (is_digit) begin
                     accum_in = (mul_acc > MAG_MAX) ? MAG_MAX[31:0] : mul_acc[31:0];
                  end else begin
                     phase_in = PH_TAIL;
                  end
               end
               PH_TAIL: begin
                  if (is_sep) begin
                     phase_in = PH_SEEK;
                  end
               end
               default: begin
                  phase_in = PH_SEEK;
               end
            endcase
         end
      end

      // Payload of a field update; status fields follow the updated state
      if (res.result_kind == RK_FIELD) begin
         res.field_id    = fid;
         res.field_value = commit_val;
      end
      res.arc_on    = (seq_in == {24'd0, cfg.arc_code});
      res.link_lost = lost_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SEEK;
         key_len_ff <= '0;
         dead_ff    <= 1'b0;
         crit_ff    <= 1'b0;
         seq_ff     <= '0;
         tick_ff    <= '0;
         lost_ff    <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         key_len_ff <= key_len_in;
         dead_ff    <= dead_in;
         crit_ff    <= crit_in;
         seq_ff     <= seq_in;
         tick_ff    <= tick_in;
         lost_ff    <= lost_in;
      end
   end

   // Key buffer and value payload
   always_ff @(posedge clock) begin
      if (step) begin
         accum_ff <= accum_in;
         neg_ff   <= neg_in;
         if (key_we) begin
            key_ff[key_widx] <= char_code;
         end
      end
   end

endmodule

FILE: hdl/telemetry_key_value_parser_top.sv
// Top level: handshakes, configuration registers and the result register.
// A result appears on rsp_* in the cycle after its input transfer.
// Throughput: one item per cycle unless rsp_ready stalls; each character is
// handled in its transfer cycle; the result register decouples the two sides.
// Reset (synchronous, active high) returns the parser to key search, clears
// the tick counter, loss flag and stored sequence state, and restores the
// loss limit to 20 and the arc state code to 5.
`timescale 1ns / 1ps

module telemetry_key_value_parser_top #(
   parameter int KEY_CHARS = tkvp_pkg::KEY_CHARS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Input channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_kind,
   input  logic [7:0]                       req_char_code,
   // Result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_result_kind,
   output logic [3:0]                       rsp_field_id,
   output logic signed [31:0]               rsp_field_value,
   output logic                             rsp_arc_on,
   output logic                             rsp_link_lost,
   output logic                             rsp_line_valid,
   // Configuration channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tkvp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tkvp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tkvp_pkg::*;

   cfg_type  cfg_ff;
   logic     rsp_valid_ff;
   rsp_type  rsp_ff;
   logic     step;
   logic     res_valid;
   rsp_type  res;

   // Configuration registers; writes always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.loss_limit <= LOSS_LIMIT_RST;
         cfg_ff.arc_code   <= ARC_CODE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LOSS_LIMIT: cfg_ff.loss_limit <= csr_data;
            CSR_ARC_CODE:   cfg_ff.arc_code   <= csr_data;
            default: ;
         endcase
      end
   end

   // Accept while the result register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   tkvp_parser #(
      .KEY_CHARS (KEY_CHARS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .kind      (req_kind),
      .char_code (req_char_code),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= res_valid;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_ff.result_kind;
   assign rsp_field_id    = rsp_ff.field_id;
   assign rsp_field_value = rsp_ff.field_value;
   assign rsp_arc_on      = rsp_ff.arc_on;
   assign rsp_link_lost   = rsp_ff.link_lost;
   assign rsp_line_valid  = rsp_ff.line_valid;

endmodule
